// ----- design/dcf_pkg.sv -----
// dcf_pkg: shared types and constants for the DC focuser pulse drive.
// No dependencies; imported by every module of the block.
package dcf_pkg;

  localparam int DIR_CHANGE_STEPS_DEF = 4;
  localparam int POSITION_BITS_DEF    = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_DATA_BITS   = 24;
  localparam int OUT_DATA_BITS  = 40;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_JOG_IN   = 3'd1;
  localparam logic [2:0] OP_JOG_OUT  = 3'd2;
  localparam logic [2:0] OP_GOTO     = 3'd3;
  localparam logic [2:0] OP_STOP     = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSES_PER_MOVE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE_ON_US    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE_OFF_US   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_HALF_US    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIR_SETTLE_US   = 3'd4;

  typedef struct packed {
    logic [6:0]  pulses_per_move;
    logic [9:0]  enable_on_us;
    logic [15:0] enable_off_us;
    logic [7:0]  step_half_us;
    logic [7:0]  dir_settle_us;
  } cfg_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_DIR_PRE  = 7'b0000010,
    PH_STEP_HI  = 7'b0000100,
    PH_STEP_LO  = 7'b0001000,
    PH_DIR_POST = 7'b0010000,
    PH_MOVE_ON  = 7'b0100000,
    PH_MOVE_OFF = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [15:0]        phase_timer;
    logic [6:0]         pulses_left;
    logic [6:0]         move_length;
    logic               dir_inward;
    logic               goto_running;
    logic signed [15:0] goto_target;
    logic signed [16:0] last_delta;
  } ctl_t;

endpackage

// ----- design/dc_focuser_pulse_drive.sv -----
// dc_focuser_pulse_drive: top level of the DC focuser pulse drive.
// Depends on dcf_pkg, dcf_cfg and dcf_step.
//
//   channel  | direction | tdata fields (lsb first)
//   ---------+-----------+------------------------------------------------------
//   s_*      | in        | op[2:0], target[18:3]
//   m_*      | out       | enable_pin, step_pin, moving_in, position[18:3],
//            |           | target_delta[35:19], busy_res, goto_active
//   cfg_*    | in        | write enable, index 0..4, 16-bit data
//
// One transaction per clock when not stalled: state update and result are
// computed in the same cycle the transaction is taken, and the result lands in
// the output register. s_tready stays high while it is empty or being drained.
// rst is synchronous and returns state, config and m_tvalid to their defaults.
// A stalled m_tready holds the result; s_tready drops only for that stall.
module dc_focuser_pulse_drive
  import dcf_pkg::*;
#(
  parameter int DIR_CHANGE_STEPS = DIR_CHANGE_STEPS_DEF,
  parameter int POSITION_BITS    = POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,   // op[2:0], target[18:3]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_BITS-1:0]  m_tdata,   // enable_pin, step_pin, moving_in,
                                               // position, target_delta, busy_res,
                                               // goto_active
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int DSW = $clog2(DIR_CHANGE_STEPS + 1);

  cfg_t                            cfg;
  ctl_t                            ctl;
  ctl_t                            ctl_next;
  logic signed [POSITION_BITS-1:0] pos;
  logic signed [POSITION_BITS-1:0] pos_next;
  logic [DSW-1:0]                  dsl;
  logic [DSW-1:0]                  dsl_next;
  logic                            accept;
  logic                            enable_pin;
  logic                            step_pin;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  dcf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcf_step #(
    .DIR_CHANGE_STEPS (DIR_CHANGE_STEPS),
    .POSITION_BITS    (POSITION_BITS)
  ) u_step (
    .cfg      (cfg),
    .op       (s_tdata[2:0]),
    .target   (s_tdata[18:3]),
    .ctl      (ctl),
    .pos      (pos),
    .dsl      (dsl),
    .ctl_next (ctl_next),
    .pos_next (pos_next),
    .dsl_next (dsl_next)
  );

  assign enable_pin = !(ctl_next.phase == PH_DIR_PRE || ctl_next.phase == PH_STEP_HI ||
                        ctl_next.phase == PH_STEP_LO || ctl_next.phase == PH_MOVE_ON);
  assign step_pin   = ctl_next.phase == PH_STEP_HI;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '{phase: PH_IDLE, default: '0};
      pos <= '0;
      dsl <= '0;
    end else if (accept) begin
      ctl <= ctl_next;
      pos <= pos_next;
      dsl <= dsl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, ctl_next.goto_running, (ctl_next.phase != PH_IDLE),
                  ctl_next.last_delta, pos_next[15:0], ctl_next.dir_inward,
                  step_pin, enable_pin};
    end
  end

endmodule

// ----- design/dcf_cfg.sv -----
// dcf_cfg: configuration register file with reset defaults.
// Depends on dcf_pkg (cfg_t, register indexes).
module dcf_cfg
  import dcf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_move <= 7'd5;
      cfg.enable_on_us    <= 10'd100;
      cfg.enable_off_us   <= 16'd2000;
      cfg.step_half_us    <= 8'd5;
      cfg.dir_settle_us   <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PULSES_PER_MOVE: cfg.pulses_per_move <= cfg_data[6:0];
        CFG_ENABLE_ON_US:    cfg.enable_on_us    <= cfg_data[9:0];
        CFG_ENABLE_OFF_US:   cfg.enable_off_us   <= cfg_data;
        CFG_STEP_HALF_US:    cfg.step_half_us    <= cfg_data[7:0];
        CFG_DIR_SETTLE_US:   cfg.dir_settle_us   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- design/dcf_step.sv -----
// dcf_step: next-state logic for one transaction (tick or command).
// Depends on dcf_pkg (cfg_t, ctl_t, phase_t, op codes).
module dcf_step
  import dcf_pkg::*;
#(
  parameter int DIR_CHANGE_STEPS = DIR_CHANGE_STEPS_DEF,
  parameter int POSITION_BITS    = POSITION_BITS_DEF,
  localparam int DSW             = $clog2(DIR_CHANGE_STEPS + 1)
) (
  input  cfg_t                            cfg,
  input  logic [2:0]                      op,
  input  logic signed [15:0]              target,
  input  ctl_t                            ctl,
  input  logic signed [POSITION_BITS-1:0] pos,
  input  logic [DSW-1:0]                  dsl,
  output ctl_t                            ctl_next,
  output logic signed [POSITION_BITS-1:0] pos_next,
  output logic [DSW-1:0]                  dsl_next
);

  localparam int DW = POSITION_BITS + 1;
  localparam logic signed [DW-1:0] DMAX = DW'(65535);
  localparam logic signed [DW-1:0] DMIN = DW'(-65536);

  logic                     busy;
  logic [6:0]               eff;
  logic                     finish;
  logic                     decide;
  logic                     start;
  logic                     st_in;
  logic [6:0]               st_len;
  logic signed [DW-1:0]     pos_sum;
  logic signed [DW-1:0]     d;
  logic [DW-1:0]            mag;

  assign busy = ctl.phase != PH_IDLE;
  assign eff  = (cfg.pulses_per_move == 7'd0) ? 7'd1 : cfg.pulses_per_move;

  always_comb begin
    ctl_next = ctl;
    pos_next = pos;
    dsl_next = dsl;
    finish   = 1'b0;
    decide   = 1'b0;
    start    = 1'b0;
    st_in    = 1'b0;
    st_len   = eff;
    pos_sum  = '0;
    d        = '0;
    mag      = '0;

    case (op)
      OP_TICK: begin
        if (busy) begin
          if (ctl.phase_timer > 16'd1) begin
            ctl_next.phase_timer = ctl.phase_timer - 16'd1;
          end else begin
            case (ctl.phase)
              PH_DIR_PRE: begin
                dsl_next             = DSW'(DIR_CHANGE_STEPS);
                ctl_next.phase       = PH_STEP_HI;
                ctl_next.phase_timer = 16'(cfg.step_half_us);
              end
              PH_STEP_HI: begin
                ctl_next.phase       = PH_STEP_LO;
                ctl_next.phase_timer = 16'(cfg.step_half_us);
              end
              PH_STEP_LO: begin
                dsl_next = dsl - DSW'(1);
                if (dsl != DSW'(1)) begin
                  ctl_next.phase       = PH_STEP_HI;
                  ctl_next.phase_timer = 16'(cfg.step_half_us);
                end else begin
                  ctl_next.phase       = PH_DIR_POST;
                  ctl_next.phase_timer = 16'(cfg.dir_settle_us);
                end
              end
              PH_DIR_POST: begin
                ctl_next.dir_inward = !ctl.dir_inward;
                if (ctl.pulses_left == 7'd0) begin
                  finish = 1'b1;
                end else begin
                  ctl_next.phase       = PH_MOVE_ON;
                  ctl_next.phase_timer = 16'(cfg.enable_on_us);
                end
              end
              PH_MOVE_ON: begin
                ctl_next.phase       = PH_MOVE_OFF;
                ctl_next.phase_timer = cfg.enable_off_us;
              end
              PH_MOVE_OFF: begin
                ctl_next.pulses_left = ctl.pulses_left - 7'd1;
                if (ctl.pulses_left != 7'd1) begin
                  ctl_next.phase       = PH_MOVE_ON;
                  ctl_next.phase_timer = 16'(cfg.enable_on_us);
                end else begin
                  finish = 1'b1;
                end
              end
              default: begin
                ctl_next.phase       = PH_IDLE;
                ctl_next.phase_timer = '0;
              end
            endcase
          end
        end
      end
      OP_JOG_IN, OP_JOG_OUT: begin
        if (!busy) begin
          ctl_next.goto_running = 1'b0;
          start  = 1'b1;
          st_in  = (op == OP_JOG_IN);
          st_len = eff;
        end
      end
      OP_GOTO: begin
        ctl_next.goto_target  = target;
        ctl_next.goto_running = 1'b1;
        decide = !busy;
      end
      OP_STOP: begin
        ctl_next.goto_running = 1'b0;
      end
      default: ;
    endcase

    // end of move: update position with saturation
    if (finish) begin
      if (ctl_next.dir_inward) begin
        pos_sum = DW'(pos) - DW'(ctl.move_length);
      end else begin
        pos_sum = DW'(pos) + DW'(ctl.move_length);
      end
      if (pos_sum[DW-1] != pos_sum[DW-2]) begin
        pos_next = pos_sum[DW-1] ? {1'b1, {(POSITION_BITS-1){1'b0}}}
                                 : {1'b0, {(POSITION_BITS-1){1'b1}}};
      end else begin
        pos_next = pos_sum[POSITION_BITS-1:0];
      end
      if (ctl.goto_running) begin
        decide = 1'b1;
      end else begin
        ctl_next.phase       = PH_IDLE;
        ctl_next.phase_timer = '0;
      end
    end

    // goto decision: size the next chunk toward the target
    if (decide) begin
      d = DW'(ctl_next.goto_target) - DW'(pos_next);
      if (d > DMAX) begin
        ctl_next.last_delta = 17'sd65535;
      end else if (d < DMIN) begin
        ctl_next.last_delta = -17'sd65536;
      end else begin
        ctl_next.last_delta = d[16:0];
      end
      mag = d[DW-1] ? -d : d;
      if (d == '0) begin
        ctl_next.goto_running = 1'b0;
        ctl_next.phase        = PH_IDLE;
        ctl_next.phase_timer  = '0;
      end else begin
        start  = 1'b1;
        st_in  = d[DW-1];
        st_len = (mag < DW'(eff)) ? mag[6:0] : eff;
      end
    end

    if (start) begin
      ctl_next.move_length = st_len;
      ctl_next.pulses_left = st_len;
      if (st_in != ctl_next.dir_inward) begin
        ctl_next.phase       = PH_DIR_PRE;
        ctl_next.phase_timer = 16'(cfg.dir_settle_us);
      end else begin
        ctl_next.phase       = PH_MOVE_ON;
        ctl_next.phase_timer = 16'(cfg.enable_on_us);
      end
    end
  end

endmodule

// ----- design/dcf_checker.sv -----
// dcf_checker: port-level assertions for dc_focuser_pulse_drive, bound to it.
// Depends on dcf_pkg for the data widths.
module dcf_checker
  import dcf_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("transaction produced no result");

  a_step_drv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0] && m_tdata[36])
    else $error("step pin high outside a driven burst");

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[36] |-> m_tdata[0] && !m_tdata[1])
    else $error("pins active while idle");

endmodule

bind dc_focuser_pulse_drive dcf_checker u_dcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
